// File: rtl/sai_pkg.sv
// Package for the shift array insert/delete block.
// Holds operation codes, field widths, capacity default and the sequencer state type.
// No dependencies.
package sai_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int OP_W    = 3;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT      = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE_AT   = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_LAST = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPLAY     = 3'd4;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WR,
        ST_SHIFT_DOWN,
        ST_DISP,
        ST_FINISH
    } t_state;

endpackage

// File: rtl/sai_in_if.sv
// Command channel of the shift array block: valid/ready plus op, index, value.
// Depends on sai_pkg for field widths.
interface sai_in_if;
    logic                                valid;
    logic                                ready;
    logic [sai_pkg::OP_W-1:0]            op;
    logic [sai_pkg::INDEX_W-1:0]         index;
    logic signed [sai_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

// File: rtl/sai_out_if.sv
// Result channel of the shift array block: valid/ready plus status, element, count, last.
// Depends on sai_pkg for field widths.
interface sai_out_if;
    logic                                valid;
    logic                                ready;
    logic                                status;
    logic                                is_element;
    logic signed [sai_pkg::VALUE_W-1:0]  element;
    logic [sai_pkg::COUNT_W-1:0]         count;
    logic                                last;

    modport source (output valid, output status, output is_element, output element,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input is_element, input element,
                    input count, input last, output ready);
endinterface

// File: rtl/sai_mem.sv
// Element store: one write port, one read port, registered read data.
// Depends on sai_pkg for the element width.
module sai_mem #(
    parameter int DEPTH = sai_pkg::CAPACITY_DEF,
    parameter int AW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [AW-1:0]                      i_wr_addr,
    input  logic signed [sai_pkg::VALUE_W-1:0] i_wr_data,
    input  logic                               i_rd_en,
    input  logic [AW-1:0]                      i_rd_addr,
    output logic signed [sai_pkg::VALUE_W-1:0] o_rd_data
);

    logic signed [sai_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [sai_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sai_ctrl.sv
// Sequencer of the shift array block: decodes commands, walks the store for
// shifts and display, and owns the output register. Depends on sai_pkg, sai_in_if, sai_out_if.
module sai_ctrl #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sai_in_if.sink                             i_in,
    sai_out_if.source                          o_out,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output logic signed [sai_pkg::VALUE_W-1:0] o_wr_data,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  logic signed [sai_pkg::VALUE_W-1:0] i_rd_data
);

    localparam int XW = (CW > sai_pkg::COUNT_W) ? CW : sai_pkg::COUNT_W;

    sai_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_size, n_size;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_idx, n_idx;
    logic signed [sai_pkg::VALUE_W-1:0] r_val, n_val;

    logic                               r_out_valid, n_out_valid;
    logic                               r_status, n_status;
    logic                               r_is_el, n_is_el;
    logic signed [sai_pkg::VALUE_W-1:0] r_element, n_element;
    logic [sai_pkg::COUNT_W-1:0]        r_count, n_count;
    logic                               r_last, n_last;

    logic          slot_free;
    logic          emit;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] size_x;
    logic [XW-1:0] cnt_x;
    logic          full;
    logic          empty;
    logic [AW-1:0] top_addr;

    assign slot_free = !r_out_valid || o_out.ready;
    assign idx_x     = XW'(i_in.index);
    assign size_x    = XW'(r_size);
    assign full      = (r_size == CW'(CAPACITY));
    assign empty     = (r_size == '0);
    assign top_addr  = AW'(r_size - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sai_pkg::ST_IDLE;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_status  <= n_status;
        r_is_el   <= n_is_el;
        r_element <= n_element;
        r_count   <= n_count;
        r_last    <= n_last;
    end

    always_comb begin
        n_state    = r_state;
        n_size     = r_size;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_val      = r_val;
        n_status   = r_status;
        n_is_el    = r_is_el;
        n_element  = r_element;
        n_count    = r_count;
        n_last     = r_last;
        emit       = 1'b0;
        i_in.ready = 1'b0;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = i_in.value;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;

        case (r_state)
            sai_pkg::ST_IDLE: begin
                i_in.ready = slot_free;
                if (i_in.valid && slot_free) begin
                    // default: single-beat completion result
                    emit      = 1'b1;
                    n_status  = sai_pkg::STATUS_OK;
                    n_is_el   = 1'b0;
                    n_element = '0;
                    n_last    = 1'b1;
                    case (i_in.op)
                        sai_pkg::OP_APPEND: begin
                            if (full) begin
                                n_status = sai_pkg::STATUS_ERR;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_size);
                                n_size    = r_size + CW'(1);
                            end
                        end
                        sai_pkg::OP_INSERT: begin
                            if (full || idx_x > size_x) begin
                                n_status = sai_pkg::STATUS_ERR;
                            end else if (idx_x == size_x) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = AW'(r_size);
                                n_size    = r_size + CW'(1);
                            end else begin
                                // shift the tail up, starting from the top
                                emit      = 1'b0;
                                n_idx     = AW'(i_in.index);
                                n_val     = i_in.value;
                                o_rd_en   = 1'b1;
                                o_rd_addr = top_addr;
                                n_ptr     = top_addr;
                                n_state   = sai_pkg::ST_SHIFT_UP;
                            end
                        end
                        sai_pkg::OP_REMOVE_AT: begin
                            if (idx_x >= size_x) begin
                                n_status = sai_pkg::STATUS_ERR;
                            end else if (idx_x == size_x - XW'(1)) begin
                                n_size = r_size - CW'(1);
                            end else begin
                                // shift the tail down, starting just above the hole
                                emit      = 1'b0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = AW'(i_in.index) + AW'(1);
                                n_ptr     = AW'(i_in.index) + AW'(1);
                                n_state   = sai_pkg::ST_SHIFT_DOWN;
                            end
                        end
                        sai_pkg::OP_REMOVE_LAST: begin
                            if (empty) begin
                                n_status = sai_pkg::STATUS_ERR;
                            end else begin
                                n_size = r_size - CW'(1);
                            end
                        end
                        sai_pkg::OP_DISPLAY: begin
                            if (!empty) begin
                                emit      = 1'b0;
                                o_rd_en   = 1'b1;
                                o_rd_addr = '0;
                                n_ptr     = '0;
                                n_state   = sai_pkg::ST_DISP;
                            end
                        end
                        default: begin
                            n_status = sai_pkg::STATUS_ERR;
                        end
                    endcase
                end
            end

            sai_pkg::ST_SHIFT_UP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr + AW'(1);
                o_wr_data = i_rd_data;
                if (r_ptr == r_idx) begin
                    n_state = sai_pkg::ST_INS_WR;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr - AW'(1);
                    n_ptr     = r_ptr - AW'(1);
                end
            end

            sai_pkg::ST_INS_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_idx;
                o_wr_data = r_val;
                n_size    = r_size + CW'(1);
                n_state   = sai_pkg::ST_FINISH;
            end

            sai_pkg::ST_SHIFT_DOWN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_ptr - AW'(1);
                o_wr_data = i_rd_data;
                if (r_ptr == top_addr) begin
                    n_size  = r_size - CW'(1);
                    n_state = sai_pkg::ST_FINISH;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr + AW'(1);
                    n_ptr     = r_ptr + AW'(1);
                end
            end

            sai_pkg::ST_DISP: begin
                // hold the read data until the output slot frees up
                if (slot_free) begin
                    emit      = 1'b1;
                    n_status  = sai_pkg::STATUS_OK;
                    n_is_el   = 1'b1;
                    n_element = i_rd_data;
                    n_last    = 1'b0;
                    if (r_ptr == top_addr) begin
                        n_state = sai_pkg::ST_FINISH;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_ptr + AW'(1);
                        n_ptr     = r_ptr + AW'(1);
                    end
                end
            end

            sai_pkg::ST_FINISH: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    n_status  = sai_pkg::STATUS_OK;
                    n_is_el   = 1'b0;
                    n_element = '0;
                    n_last    = 1'b1;
                    n_state   = sai_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sai_pkg::ST_IDLE;
            end
        endcase

        cnt_x = XW'(n_size);
        if (emit) begin
            n_count = cnt_x[sai_pkg::COUNT_W-1:0];
        end
        n_out_valid = emit || (r_out_valid && !o_out.ready);
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.is_element = r_is_el;
    assign o_out.element    = r_element;
    assign o_out.count      = r_count;
    assign o_out.last       = r_last;

endmodule

// File: rtl/shift_array_insert_delete.sv
// Top level of the fixed-capacity shift array with insert and delete.
// Depends on sai_pkg, sai_in_if, sai_out_if, sai_mem and sai_ctrl.
//
//   channel   dir  handshake     beat payload
//   i_in      in   valid/ready   op, index, value
//   o_out     out  valid/ready   status, is_element, element, count, last
//
// Append, remove-last, remove of the last element, insert at the end, display of
// an empty array and all error cases complete in the idle state. Insert at index k
// and remove at index k move the tail of the store, one store entry per cycle
// through the single read and single write port. Any other display reads the
// elements out in order. Reset clears the count and the sequencer, not the store.
// A stalled output register holds display and finish, not shifts; no new command is taken.
module shift_array_insert_delete #(
    parameter int CAPACITY = sai_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sai_in_if.sink     i_in,
    sai_out_if.source  o_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic signed [sai_pkg::VALUE_W-1:0] wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic signed [sai_pkg::VALUE_W-1:0] rd_data;

    sai_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    sai_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
